// ----- design/lobg_pkg.sv -----
// Shared constants and controller/datapath interface types for the bar-graph AGC meter.
`default_nettype none

package lobg_pkg;

    // Bar-graph geometry.
    localparam int SEGMENTS    = 9;
    localparam int FULL_BRIGHT = 255;
    localparam int BRIGHT_W    = 8;

    // Scale of the full bar: level * SCALE spans all segments at the ceiling.
    localparam int SCALE     = SEGMENTS * FULL_BRIGHT;
    localparam int SCALE_W   = $clog2(SCALE + 1);

    // Field widths.
    localparam int LEVEL_W   = 16;
    localparam int ATTACK_W  = 17;
    localparam int DECAY_W   = 16;
    localparam int FLOOR_W   = 16;
    localparam int FRAC_W    = 16;
    localparam int CEIL_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // Numerator level * SCALE and the divider that splits it by the ceiling.
    localparam int NUM_W     = LEVEL_W + SCALE_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd2;

    // Reset values.
    localparam logic [ATTACK_W-1:0] ATTACK_RST = 17'd78643;
    localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd65208;
    localparam logic [FLOOR_W-1:0]  FLOOR_RST  = 16'd500;
    localparam logic [CEIL_W-1:0]   CEIL_RST   = 32'd1000 << FRAC_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic update;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/lobg_ctrl.sv -----
// Controller state machine that sequences the ceiling update, the divider and the result load.
`default_nettype none

module lobg_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lobg_pkg::t_dp_stat i_stat,
    output lobg_pkg::t_dp_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [lobg_pkg::CNT_W-1:0] LAST_STEP =
        lobg_pkg::CNT_W'(lobg_pkg::DIV_STEPS - 1);

    logic [1:0]                 r_state, n_state;
    logic [lobg_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold the finished quotient until the output register is free.
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // The step counter never runs past the last divider step.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= LAST_STEP))
        else $error("divider step counter out of range");

    // An accepted beat always starts the ceiling update next.
    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> (r_state == S_UPD))
        else $error("accepted beat did not start an update");

endmodule

`default_nettype wire

// ----- design/lobg_dp.sv -----
// Datapath: configuration registers, tracked ceiling, serial divider and result register.
`default_nettype none

module lobg_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire lobg_pkg::t_dp_cmd                    i_cmd,
    output lobg_pkg::t_dp_stat                        o_stat,
    input  wire logic                                 i_cfg_we,
    input  wire logic [lobg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [lobg_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  wire logic [lobg_pkg::LEVEL_W-1:0]         i_level,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic [lobg_pkg::SEGMENTS-1:0][lobg_pkg::BRIGHT_W-1:0] o_seg,
    output logic [lobg_pkg::FLOOR_W-1:0]              o_ceiling_whole
);

    localparam int LW = lobg_pkg::LEVEL_W;
    localparam int CW = lobg_pkg::CEIL_W;
    localparam int FW = lobg_pkg::FRAC_W;
    localparam int NW = lobg_pkg::NUM_W;
    localparam int SW = lobg_pkg::SCALE_W;
    localparam int BW = lobg_pkg::BRIGHT_W;

    localparam logic [SW-1:0] SCALE_K = SW'(lobg_pkg::SCALE);
    localparam logic [SW-1:0] FULL_K  = SW'(lobg_pkg::FULL_BRIGHT);

    logic [lobg_pkg::ATTACK_W-1:0] r_attack;
    logic [lobg_pkg::DECAY_W-1:0]  r_decay;
    logic [lobg_pkg::FLOOR_W-1:0]  r_floor;
    logic [CW-1:0]                 r_ceil;
    logic [LW-1:0]                 r_level;
    logic [CW-1:0]                 r_rem;
    logic [NW-1:0]                 r_dq;
    logic                          r_out_valid;
    logic [lobg_pkg::SEGMENTS-1:0][BW-1:0] r_seg;
    logic [lobg_pkg::FLOOR_W-1:0]  r_cw;

    logic [CW-1:0]                 n_ceil;
    logic [CW:0]                   attack_prod;
    logic [CW+lobg_pkg::DECAY_W-1:0] decay_prod;
    logic [lobg_pkg::FLOOR_W-1:0]  floor_eff;
    logic [CW-1:0]                 floor_q;
    logic [CW-1:0]                 pre_floor;
    logic [NW-1:0]                 num;
    logic [CW:0]                   div_trial;
    logic                          div_fit;
    logic [SW-1:0]                 sval;
    logic [lobg_pkg::SEGMENTS-1:0][BW-1:0] n_seg;

    // Configuration writes; an unused index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= lobg_pkg::ATTACK_RST;
            r_decay  <= lobg_pkg::DECAY_RST;
            r_floor  <= lobg_pkg::FLOOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lobg_pkg::CFG_ATTACK: r_attack <= i_cfg_data;
                lobg_pkg::CFG_DECAY:  r_decay  <= i_cfg_data[lobg_pkg::DECAY_W-1:0];
                lobg_pkg::CFG_FLOOR:  r_floor  <= i_cfg_data[lobg_pkg::FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Ceiling update: attack above the ceiling, decay otherwise, then floor.
    always_comb begin
        attack_prod = (CW+1)'(r_level * r_attack);
        decay_prod  = r_ceil * r_decay;
        floor_eff   = (r_floor == '0) ? lobg_pkg::FLOOR_W'(1) : r_floor;
        floor_q     = {floor_eff, {FW{1'b0}}};
        if ({r_level, {FW{1'b0}}} > r_ceil) begin
            pre_floor = attack_prod[CW] ? {CW{1'b1}} : attack_prod[CW-1:0];
        end else begin
            pre_floor = decay_prod[CW+lobg_pkg::DECAY_W-1:lobg_pkg::DECAY_W];
        end
        n_ceil = (pre_floor < floor_q) ? floor_q : pre_floor;
        num    = NW'(r_level * SCALE_K);
    end

    // One restoring divider step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        div_trial = {r_rem, r_dq[NW-1]};
        div_fit   = (div_trial >= {1'b0, r_ceil});
    end

    // Level, ceiling and divider registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceil <= lobg_pkg::CEIL_RST;
        end else if (i_cmd.update) begin
            r_ceil <= n_ceil;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_level <= i_level;
        end
        if (i_cmd.update) begin
            // The top bits of (num << FRAC_W) are always below the ceiling.
            r_rem <= {{(CW-FW){1'b0}}, num[NW-1:NW-FW]};
            r_dq  <= {num[NW-FW-1:0], {FW{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= div_fit ? CW'(div_trial - {1'b0, r_ceil}) : div_trial[CW-1:0];
            r_dq  <= {r_dq[NW-2:0], div_fit};
        end
    end

    // Brightness per segment from the clamped quotient.
    always_comb begin
        logic [SW-1:0] base;
        logic [SW-1:0] diff;
        sval = (r_dq > NW'({SW{1'b1}})) ? {SW{1'b1}} : r_dq[SW-1:0];
        for (int i = 0; i < lobg_pkg::SEGMENTS; i++) begin
            base = SW'(i * lobg_pkg::FULL_BRIGHT);
            diff = sval - base;
            if (sval <= base) begin
                n_seg[i] = '0;
            end else if (diff > FULL_K) begin
                n_seg[i] = {BW{1'b1}};
            end else begin
                n_seg[i] = diff[BW-1:0];
            end
        end
    end

    // Result register; a beat waits here while the next item is taken in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_seg <= n_seg;
            r_cw  <= r_ceil[CW-1:FW];
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_seg            = r_seg;
    assign o_ceiling_whole  = r_cw;

    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // A waiting result is not dropped without a beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("waiting result dropped");

endmodule

`default_nettype wire

// ----- design/light_organ_bar_graph_agc_core.sv -----
// Top level of the bar-graph level meter with peak-tracking automatic gain control.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+------------------------------------
//  input    | in        | i_in_valid / o_in_ready    | i_level
//  result   | out       | o_out_valid / i_out_ready  | o_seg0..o_seg8_bright, o_ceiling_whole
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A result passes through the ceiling update, the radix-2 restoring divider (one quotient bit
// a cycle) and the result load, which waits until the result register is free. The beat's
// own cycle captures the level; no new item is taken until the last one's result is loaded.
// Reset restores the register defaults and sets the ceiling to 1000.0; no clearing pass runs.
// The result register frees the datapath, so a stalled result delays only the next load.
`default_nettype none

module light_organ_bar_graph_agc_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [lobg_pkg::LEVEL_W-1:0]       i_level,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg0_bright,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg1_bright,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg2_bright,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg3_bright,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg4_bright,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg5_bright,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg6_bright,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg7_bright,
    output logic [lobg_pkg::BRIGHT_W-1:0]           o_seg8_bright,
    output logic [lobg_pkg::FLOOR_W-1:0]            o_ceiling_whole,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lobg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lobg_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    lobg_pkg::t_dp_cmd  cmd;
    lobg_pkg::t_dp_stat stat;
    logic [lobg_pkg::SEGMENTS-1:0][lobg_pkg::BRIGHT_W-1:0] seg;

    // Configuration writes are taken at any time.
    assign o_cfg_ready = 1'b1;

    lobg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lobg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_level         (i_level),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_seg           (seg),
        .o_ceiling_whole (o_ceiling_whole)
    );

    // Segment outputs, lowest first.
    assign o_seg0_bright = seg[0];
    assign o_seg1_bright = seg[1];
    assign o_seg2_bright = seg[2];
    assign o_seg3_bright = seg[3];
    assign o_seg4_bright = seg[4];
    assign o_seg5_bright = seg[5];
    assign o_seg6_bright = seg[6];
    assign o_seg7_bright = seg[7];
    assign o_seg8_bright = seg[8];

endmodule

`default_nettype wire
